// File: src/sqsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sequence quality statistics accumulator.
// No dependencies; imported by the top level.
package sqsa_pkg;

  // Default depth of the per-position table
  localparam int unsigned MAX_POSITIONS_DEF = 4096;

  // Field widths fixed by the interface
  localparam int unsigned QUAL_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned QPOS_W     = 12;
  localparam int unsigned RTOT_W     = 24;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned BASES_W    = 48;
  localparam int unsigned ENTRY_W    = SUM_W + CNT_W;
  // Position width with one spare bit, so the table depth itself fits
  localparam int unsigned POS_EXT_W  = LEN_W + 1;
  // Divider works on 8 quotient bits
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned STEP_W     = 3;

  localparam logic [QUAL_W-1:0] PHRED_OFFSET_RST = 8'd33;

  // Input command codes
  localparam logic CMD_SYMBOL = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result kind codes
  localparam logic KIND_SUMMARY  = 1'b0;
  localparam logic KIND_POSITION = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_QRY,
    ST_CLAMP,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// File: src/sequence_quality_stats_accumulator.sv
`timescale 1ns / 1ps
// Phred quality statistics accumulator: per-position table, read summaries.
// Depends on sqsa_pkg for widths, codes and the sequencer state type.

// Usage: after reset the block sweeps its per-position table to zero, one
// entry per cycle, and holds in_stall high until the sweep is done. A
// quality symbol then takes a table read, then a table write; a query takes
// a table read, then a result load. A read end runs further steps after the
// symbol or the end request: one range check for the 255 clamp, eight steps
// of the shared compare-subtract unit for the 8-bit truncated mean, and a
// final step to fold in the read statistics; an empty read or a clamped mean
// skips the eight divider steps. Only one request is in flight at a time; a
// finished result sits in the output register, so the next request is taken
// while the previous result is still stalled, and a query or read end that
// finds the output register still full holds in its final state until it
// drains.
module sequence_quality_stats_accumulator #(
  parameter int unsigned MAX_POSITIONS = sqsa_pkg::MAX_POSITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sqsa_pkg::QUAL_W-1:0]   cfg_data,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic                          in_symbol_valid,
  input  logic [sqsa_pkg::QUAL_W-1:0]   in_qual_byte,
  input  logic                          in_last_of_read,
  input  logic [sqsa_pkg::LEN_W-1:0]    in_seq_length,
  input  logic [sqsa_pkg::QPOS_W-1:0]   in_query_position,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [sqsa_pkg::QUAL_W-1:0]   out_read_mean_qual,
  output logic [sqsa_pkg::CNT_W-1:0]    out_reads_seen,
  output logic [sqsa_pkg::BASES_W-1:0]  out_total_bases,
  output logic [sqsa_pkg::LEN_W-1:0]    out_shortest_read,
  output logic [sqsa_pkg::LEN_W-1:0]    out_longest_read,
  output logic [sqsa_pkg::SUM_W-1:0]    out_sum_of_read_means,
  output logic [sqsa_pkg::SUM_W-1:0]    out_position_qual_total,
  output logic [sqsa_pkg::CNT_W-1:0]    out_position_base_count,
  output logic                          out_range_flag
);

  import sqsa_pkg::*;

  localparam int unsigned AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam logic [POS_EXT_W-1:0] MAX_POS_EXT = POS_EXT_W'(MAX_POSITIONS);
  localparam logic [AW-1:0]        LAST_ADDR   = AW'(MAX_POSITIONS - 1);

  // Per-position table: {sum, count}
  logic [ENTRY_W-1:0] tab_mem [MAX_POSITIONS];

  // Control state
  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [QUAL_W-1:0]   off_r, off_nxt;
  logic [LEN_W-1:0]    cpos_r, cpos_nxt;
  logic [RTOT_W-1:0]   rtot_r, rtot_nxt;
  logic [CNT_W-1:0]    rcnt_r, rcnt_nxt;
  logic [BASES_W-1:0]  btot_r, btot_nxt;
  logic [LEN_W-1:0]    minl_r, minl_nxt;
  logic [LEN_W-1:0]    maxl_r, maxl_nxt;
  logic [SUM_W-1:0]    msum_r, msum_nxt;
  logic                flag_r, flag_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request and divider payload
  logic [QUAL_W-1:0]   v_r, v_nxt;
  logic                last_r, last_nxt;
  logic [LEN_W-1:0]    rlen_r, rlen_nxt;
  logic                qhit_r, qhit_nxt;
  logic                inrng_r, inrng_nxt;
  logic [RTOT_W-1:0]   rem_r, rem_nxt;
  logic [RTOT_W-1:0]   div_r, div_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ENTRY_W-1:0]  rd_data_r;

  // Result register
  logic                out_kind_r, out_kind_nxt;
  logic [QUAL_W-1:0]   out_mean_r, out_mean_nxt;
  logic [CNT_W-1:0]    out_reads_r, out_reads_nxt;
  logic [BASES_W-1:0]  out_bases_r, out_bases_nxt;
  logic [LEN_W-1:0]    out_short_r, out_short_nxt;
  logic [LEN_W-1:0]    out_long_r, out_long_nxt;
  logic [SUM_W-1:0]    out_msum_r, out_msum_nxt;
  logic [SUM_W-1:0]    out_ptot_r, out_ptot_nxt;
  logic [CNT_W-1:0]    out_pcnt_r, out_pcnt_nxt;
  logic                out_flag_r, out_flag_nxt;

  // Combinational helpers
  logic                 in_acc;
  logic                 out_free;
  logic [POS_EXT_W-1:0] pos_ext;
  logic [POS_EXT_W-1:0] qpos_ext;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [QUAL_W:0]      qsub;
  logic [RTOT_W-1:0]    alu_a, alu_b;
  logic [RTOT_W:0]      alu_diff;
  logic                 alu_borrow;
  logic [SUM_W-1:0]     ent_sum;
  logic [CNT_W-1:0]     ent_cnt;
  logic [SUM_W:0]       sum_add;
  logic [RTOT_W:0]      tot_add;
  logic [BASES_W:0]     bases_add;
  logic [SUM_W:0]       msum_add;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign pos_ext  = {1'b0, cpos_r};
  assign qpos_ext = POS_EXT_W'(in_query_position);
  assign rd_addr  = (in_command == CMD_QUERY) ? qpos_ext[AW-1:0] : pos_ext[AW-1:0];

  // Offset subtraction for the incoming character
  assign qsub = {1'b0, in_qual_byte} - {1'b0, off_r};

  // Shared compare-subtract unit: clamp test, then one quotient bit a step
  assign alu_a      = (state_r == ST_CLAMP) ? rtot_r : rem_r;
  assign alu_b      = (state_r == ST_CLAMP) ? {cpos_r, 8'b0} : div_r;
  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[RTOT_W];

  // Saturating updates of the table entry and the read accumulators
  assign ent_sum   = rd_data_r[ENTRY_W-1:CNT_W];
  assign ent_cnt   = rd_data_r[CNT_W-1:0];
  assign sum_add   = {1'b0, ent_sum} + (SUM_W + 1)'(v_r);
  assign tot_add   = {1'b0, rtot_r} + (RTOT_W + 1)'(v_r);
  assign bases_add = {1'b0, btot_r} + (BASES_W + 1)'(rlen_r);
  assign msum_add  = {1'b0, msum_r} + (SUM_W + 1)'(quo_r);

  // Table write port: clearing sweep or accumulate
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_ACC && inrng_r) begin
      mem_we    = 1'b1;
      mem_waddr = pos_ext[AW-1:0];
      mem_wdata = {sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0],
                   (&ent_cnt) ? ent_cnt : ent_cnt + CNT_W'(1)};
    end
  end

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    off_nxt       = off_r;
    cpos_nxt      = cpos_r;
    rtot_nxt      = rtot_r;
    rcnt_nxt      = rcnt_r;
    btot_nxt      = btot_r;
    minl_nxt      = minl_r;
    maxl_nxt      = maxl_r;
    msum_nxt      = msum_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    v_nxt         = v_r;
    last_nxt      = last_r;
    rlen_nxt      = rlen_r;
    qhit_nxt      = qhit_r;
    inrng_nxt     = inrng_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_kind_nxt  = out_kind_r;
    out_mean_nxt  = out_mean_r;
    out_reads_nxt = out_reads_r;
    out_bases_nxt = out_bases_r;
    out_short_nxt = out_short_r;
    out_long_nxt  = out_long_r;
    out_msum_nxt  = out_msum_r;
    out_ptot_nxt  = out_ptot_r;
    out_pcnt_nxt  = out_pcnt_r;
    out_flag_nxt  = out_flag_r;

    // Take configuration writes at any time
    if (cfg_valid && cfg_ready) begin
      off_nxt = cfg_data;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last_of_read;
          rlen_nxt = in_seq_length;
          qhit_nxt = (qpos_ext < MAX_POS_EXT);
          if (in_command == CMD_QUERY) begin
            state_nxt = ST_QRY;
          end else if (in_symbol_valid) begin
            // Clip below offset to zero; flag below-offset and off-table symbols
            v_nxt     = qsub[QUAL_W] ? '0 : qsub[QUAL_W-1:0];
            inrng_nxt = (pos_ext < MAX_POS_EXT);
            if (qsub[QUAL_W] || !(pos_ext < MAX_POS_EXT)) begin
              flag_nxt = 1'b1;
            end
            state_nxt = ST_ACC;
          end else if (in_last_of_read) begin
            state_nxt = ST_CLAMP;
          end
        end
      end

      ST_ACC: begin
        rtot_nxt  = tot_add[RTOT_W] ? {RTOT_W{1'b1}} : tot_add[RTOT_W-1:0];
        cpos_nxt  = (&cpos_r) ? cpos_r : cpos_r + LEN_W'(1);
        state_nxt = last_r ? ST_CLAMP : ST_IDLE;
      end

      ST_QRY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_POSITION;
          out_mean_nxt  = '0;
          out_reads_nxt = rcnt_r;
          out_bases_nxt = btot_r;
          out_short_nxt = minl_r;
          out_long_nxt  = maxl_r;
          out_msum_nxt  = msum_r;
          out_ptot_nxt  = qhit_r ? ent_sum : '0;
          out_pcnt_nxt  = qhit_r ? ent_cnt : '0;
          out_flag_nxt  = flag_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CLAMP: begin
        // Empty read gives zero; quotient of 256 or more clamps to 255
        priority if (cpos_r == '0) begin
          quo_nxt   = '0;
          state_nxt = ST_FIN;
        end else if (!alu_borrow) begin
          quo_nxt   = {QUO_W{1'b1}};
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = rtot_r;
          div_nxt   = RTOT_W'({cpos_r, 7'b0});
          quo_nxt   = '0;
          step_nxt  = STEP_W'(QUO_W - 1);
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (!alu_borrow) begin
          rem_nxt = alu_diff[RTOT_W-1:0];
        end
        quo_nxt  = {quo_r[QUO_W-2:0], !alu_borrow};
        div_nxt  = div_r >> 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          rcnt_nxt = (&rcnt_r) ? rcnt_r : rcnt_r + CNT_W'(1);
          btot_nxt = bases_add[BASES_W] ? {BASES_W{1'b1}} : bases_add[BASES_W-1:0];
          minl_nxt = (rlen_r < minl_r) ? rlen_r : minl_r;
          maxl_nxt = (rlen_r > maxl_r) ? rlen_r : maxl_r;
          msum_nxt = msum_add[SUM_W] ? {SUM_W{1'b1}} : msum_add[SUM_W-1:0];
          cpos_nxt = '0;
          rtot_nxt = '0;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SUMMARY;
          out_mean_nxt  = quo_r;
          out_reads_nxt = rcnt_nxt;
          out_bases_nxt = btot_nxt;
          out_short_nxt = minl_nxt;
          out_long_nxt  = maxl_nxt;
          out_msum_nxt  = msum_nxt;
          out_ptot_nxt  = '0;
          out_pcnt_nxt  = '0;
          out_flag_nxt  = flag_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      off_r       <= PHRED_OFFSET_RST;
      cpos_r      <= '0;
      rtot_r      <= '0;
      rcnt_r      <= '0;
      btot_r      <= '0;
      minl_r      <= {LEN_W{1'b1}};
      maxl_r      <= '0;
      msum_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      off_r       <= off_nxt;
      cpos_r      <= cpos_nxt;
      rtot_r      <= rtot_nxt;
      rcnt_r      <= rcnt_nxt;
      btot_r      <= btot_nxt;
      minl_r      <= minl_nxt;
      maxl_r      <= maxl_nxt;
      msum_r      <= msum_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    last_r      <= last_nxt;
    rlen_r      <= rlen_nxt;
    qhit_r      <= qhit_nxt;
    inrng_r     <= inrng_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    out_kind_r  <= out_kind_nxt;
    out_mean_r  <= out_mean_nxt;
    out_reads_r <= out_reads_nxt;
    out_bases_r <= out_bases_nxt;
    out_short_r <= out_short_nxt;
    out_long_r  <= out_long_nxt;
    out_msum_r  <= out_msum_nxt;
    out_ptot_r  <= out_ptot_nxt;
    out_pcnt_r  <= out_pcnt_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  // Table memory: one write port, registered read on request accept
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tab_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= tab_mem[rd_addr];
    end
  end

  assign out_valid               = out_valid_r;
  assign out_result_kind         = out_kind_r;
  assign out_read_mean_qual      = out_mean_r;
  assign out_reads_seen          = out_reads_r;
  assign out_total_bases         = out_bases_r;
  assign out_shortest_read       = out_short_r;
  assign out_longest_read        = out_long_r;
  assign out_sum_of_read_means   = out_msum_r;
  assign out_position_qual_total = out_ptot_r;
  assign out_position_base_count = out_pcnt_r;
  assign out_range_flag          = out_flag_r;

`ifndef SYNTHESIS
  // Divider remainder stays below the divisor scaled by the quotient range
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {cpos_r, 8'b0}))
    else $error("divider remainder out of range");

  // Once a read is finished, shortest never exceeds longest
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (rcnt_r != '0) |-> (minl_r <= maxl_r))
    else $error("shortest read exceeds longest read");

  // Table writes only land inside the table
  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (POS_EXT_W'(mem_waddr) < MAX_POS_EXT))
    else $error("table write beyond depth");

  // After a summary is loaded, the read accumulators are cleared
  a_summary_clears_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (cpos_r == '0 && rtot_r == '0))
    else $error("read accumulators not cleared after summary");
`endif

endmodule
